// File: rtl/core/dtdp_pkg.sv
// Package for the dual trigger-delay pulse block.
// Holds widths, constants, register indexes and the transaction payload types.
// No dependencies.
package dtdp_pkg;

    localparam int TICK_BITS     = 19;
    localparam int VOLT_BITS     = 16;
    localparam int CV_BITS       = 14;
    localparam int FULL_SCALE    = 8192;
    localparam int MIN_LEN_CV    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (TICK_BITS > VOLT_BITS) ? TICK_BITS : VOLT_BITS;

    localparam int LENGTH_RESET    = 4800;
    localparam int THRESH_LO_RESET = 0;
    localparam int THRESH_HI_RESET = 819;

    typedef logic        [TICK_BITS-1:0] t_ticks;
    typedef logic signed [VOLT_BITS-1:0] t_volt;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DELAY_A,
        CFG_DELAY_B,
        CFG_LENGTH_A,
        CFG_LENGTH_B,
        CFG_THRESH_LO,
        CFG_THRESH_HI
    } t_cfg_idx;

    typedef struct packed {
        t_volt gate_a_level;
        logic  gate_a_connected;
        t_volt gate_b_level;
        logic  gate_b_connected;
        t_volt delay_a_cv;
        logic  delay_a_cv_connected;
        t_volt delay_b_cv;
        logic  delay_b_cv_connected;
        t_volt length_a_cv;
        logic  length_a_cv_connected;
        t_volt length_b_cv;
        logic  length_b_cv_connected;
    } t_in_item;

    typedef struct packed {
        logic pulse_a_out;
        logic pulse_b_out;
    } t_out_item;

    // per-channel work after scaling
    typedef struct packed {
        t_volt  gate_level;
        logic   gate_connected;
        t_ticks delay_ticks;
        t_ticks length_ticks;
    } t_chan_in;

endpackage

// File: rtl/core/dtdp_scale.sv
// CV scaling of a tick count: ceil(base * clamp(cv) / full scale), or base when the CV is not connected.
// Depends on dtdp_pkg.
module dtdp_scale import dtdp_pkg::*; #(
    parameter int MIN_CV = 0
) (
    input  t_ticks i_base,
    input  t_volt  i_cv,
    input  logic   i_cv_connected,
    output t_ticks o_scaled
);

    localparam t_volt CV_LO = t_volt'(MIN_CV);
    localparam t_volt CV_HI = t_volt'(FULL_SCALE);
    localparam int    PROD_BITS = TICK_BITS + CV_BITS;

    logic [CV_BITS-1:0]   w_cv;
    logic [PROD_BITS-1:0] w_prod;

    always_comb begin
        priority if (i_cv < CV_LO) begin
            w_cv = CV_BITS'(MIN_CV);
        end else if (i_cv > CV_HI) begin
            w_cv = CV_BITS'(FULL_SCALE);
        end else begin
            w_cv = i_cv[CV_BITS-1:0];
        end
    end

    assign w_prod   = PROD_BITS'(i_base) * PROD_BITS'(w_cv) + PROD_BITS'(FULL_SCALE - 1);
    assign o_scaled = i_cv_connected ? w_prod[CV_BITS-1 +: TICK_BITS] : i_base;

endmodule

// File: rtl/core/dtdp_chan.sv
// One channel: Schmitt trigger, delay counter and pulse counter.
// Depends on dtdp_pkg.
module dtdp_chan import dtdp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_chan_in i_work,
    input  t_volt    i_thresh_lo,
    input  t_volt    i_thresh_hi,
    output logic     o_pulse
);

    logic   r_sch, n_sch;
    logic   r_armed, n_armed;
    t_ticks r_drem, n_drem;
    t_ticks r_prem, n_prem;

    always_comb begin
        n_sch   = r_sch;
        n_armed = r_armed;
        n_drem  = r_drem;
        n_prem  = r_prem;
        if (i_work.gate_connected) begin
            if (!r_sch) begin
                if (i_work.gate_level >= i_thresh_hi) begin
                    n_sch   = 1'b1;
                    n_drem  = i_work.delay_ticks;
                    n_armed = 1'b1;
                end
            end else if (i_work.gate_level <= i_thresh_lo) begin
                n_sch = 1'b0;
            end
        end
        if (n_armed) begin
            if (n_drem != '0) begin
                n_drem = n_drem - 1'b1;
            end
            if (n_drem == '0) begin
                n_armed = 1'b0;
                n_prem  = i_work.length_ticks;
            end
        end
        if (n_prem != '0) begin
            n_prem = n_prem - 1'b1;
        end
        o_pulse = (n_prem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sch   <= 1'b0;
            r_armed <= 1'b0;
            r_drem  <= '0;
            r_prem  <= '0;
        end else if (i_step) begin
            r_sch   <= n_sch;
            r_armed <= n_armed;
            r_drem  <= n_drem;
            r_prem  <= n_prem;
        end
    end

    a_armed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_drem != '0))
        else $error("armed with zero delay count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_sch) && $stable(r_armed) && $stable(r_drem) && $stable(r_prem)))
        else $error("channel state moved without a step");

    a_pulse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_armed && (!i_work.gate_connected || r_sch) && r_prem != '0)
        |=> (r_prem + 1'b1 == $past(r_prem)))
        else $error("pulse count did not step down");

endmodule

// File: rtl/core/dual_trigger_delay_pulse.sv
// Top level of the dual trigger-delay pulse block.
// Depends on dtdp_pkg, dtdp_scale and dtdp_chan.
//
// Usage: one input transaction per sample tick on i_in_valid/o_in_ready with
// payload i_in_data; one result transaction per input on o_out_valid/
// i_out_ready with payload o_out_data (two pulse levels).
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high,
// only while the block is idle. Unknown indexes are ignored.
// An accepted transaction passes the input register, then the result
// register. One transaction per cycle while the receiver is ready; CV
// scaling and the counter update run in one pass between the two registers.
// Reset (synchronous, active low) empties both registers, clears all channel
// state and loads the register defaults.
// Receiver stall: the result register holds; the input register takes one
// more transaction, then o_in_ready drops.
module dual_trigger_delay_pulse import dtdp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_ticks r_delay_a, r_delay_b, r_length_a, r_length_b;
    t_volt  r_thresh_lo, r_thresh_hi;

    logic      r_s1_valid, r_out_valid;
    t_in_item  r_s1_data;
    t_out_item r_out;

    logic     w_adv, w_s1_free, w_out_free;
    t_ticks   w_dly_a, w_dly_b, w_len_a, w_len_b;
    t_chan_in w_work_a, w_work_b;
    logic     w_pulse_a, w_pulse_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_a   <= '0;
            r_delay_b   <= '0;
            r_length_a  <= t_ticks'(LENGTH_RESET);
            r_length_b  <= t_ticks'(LENGTH_RESET);
            r_thresh_lo <= t_volt'(THRESH_LO_RESET);
            r_thresh_hi <= t_volt'(THRESH_HI_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DELAY_A:   r_delay_a   <= i_cfg_data[TICK_BITS-1:0];
                CFG_DELAY_B:   r_delay_b   <= i_cfg_data[TICK_BITS-1:0];
                CFG_LENGTH_A:  r_length_a  <= i_cfg_data[TICK_BITS-1:0];
                CFG_LENGTH_B:  r_length_b  <= i_cfg_data[TICK_BITS-1:0];
                CFG_THRESH_LO: r_thresh_lo <= i_cfg_data[VOLT_BITS-1:0];
                CFG_THRESH_HI: r_thresh_hi <= i_cfg_data[VOLT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_s1_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_adv;
    assign o_in_ready = w_s1_free;

    dtdp_scale #(.MIN_CV(0)) u_scale_dly_a (
        .i_base(r_delay_a), .i_cv(r_s1_data.delay_a_cv),
        .i_cv_connected(r_s1_data.delay_a_cv_connected), .o_scaled(w_dly_a)
    );
    dtdp_scale #(.MIN_CV(0)) u_scale_dly_b (
        .i_base(r_delay_b), .i_cv(r_s1_data.delay_b_cv),
        .i_cv_connected(r_s1_data.delay_b_cv_connected), .o_scaled(w_dly_b)
    );
    dtdp_scale #(.MIN_CV(MIN_LEN_CV)) u_scale_len_a (
        .i_base(r_length_a), .i_cv(r_s1_data.length_a_cv),
        .i_cv_connected(r_s1_data.length_a_cv_connected), .o_scaled(w_len_a)
    );
    dtdp_scale #(.MIN_CV(MIN_LEN_CV)) u_scale_len_b (
        .i_base(r_length_b), .i_cv(r_s1_data.length_b_cv),
        .i_cv_connected(r_s1_data.length_b_cv_connected), .o_scaled(w_len_b)
    );

    assign w_work_a = '{gate_level: r_s1_data.gate_a_level,
                        gate_connected: r_s1_data.gate_a_connected,
                        delay_ticks: w_dly_a, length_ticks: w_len_a};
    assign w_work_b = '{gate_level: r_s1_data.gate_b_level,
                        gate_connected: r_s1_data.gate_b_connected,
                        delay_ticks: w_dly_b, length_ticks: w_len_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_s1_free) begin
            r_s1_data <= i_in_data;
        end
        if (w_adv) begin
            r_out.pulse_a_out <= w_pulse_a;
            r_out.pulse_b_out <= w_pulse_b;
        end
    end

    dtdp_chan u_chan_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_adv), .i_work(w_work_a),
        .i_thresh_lo(r_thresh_lo), .i_thresh_hi(r_thresh_hi), .o_pulse(w_pulse_a)
    );
    dtdp_chan u_chan_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_adv), .i_work(w_work_b),
        .i_thresh_lo(r_thresh_lo), .i_thresh_hi(r_thresh_hi), .o_pulse(w_pulse_b)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_in_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("accepted transaction not held in input register");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("channel step without a result");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_data)))
        else $error("stalled input register lost its transaction");

endmodule
